FILE: design/tnle_pkg.sv
package tnle_pkg;

   // Width of the result sequence index (covers the message table and the line store).
   localparam int SEQ_W = 6;

   // Telnet command and option bytes.
   localparam logic [7:0] B_IAC    = 8'hFF;
   localparam logic [7:0] B_DONT   = 8'hFE;
   localparam logic [7:0] B_DO     = 8'hFD;
   localparam logic [7:0] B_WONT   = 8'hFC;
   localparam logic [7:0] B_WILL   = 8'hFB;
   localparam logic [7:0] OPT_ECHO = 8'h01;
   localparam logic [7:0] OPT_SGA  = 8'h03;

   // Control characters of the line editor.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // Status event codes.
   localparam logic STAT_REFUSED  = 1'b0;
   localparam logic STAT_OVERFLOW = 1'b1;

   // Spans of the message table.
   localparam logic [SEQ_W-1:0] ROM_GREET_FIRST  = 6'd0;
   localparam logic [SEQ_W-1:0] ROM_GREET_LAST   = 6'd5;
   localparam logic [SEQ_W-1:0] ROM_SGA_FIRST    = 6'd6;
   localparam logic [SEQ_W-1:0] ROM_PROMPT_FIRST = 6'd20;
   localparam logic [SEQ_W-1:0] ROM_SGA_LAST     = 6'd22;
   localparam logic [SEQ_W-1:0] ROM_ECHO_FIRST   = 6'd23;
   localparam logic [SEQ_W-1:0] ROM_ECHO_LAST    = 6'd39;

   typedef enum logic [2:0] {
      PS_TEXT   = 3'd0,
      PS_IAC    = 3'd1,
      PS_VERB   = 3'd2,
      PS_CR     = 3'd3,
      PS_CLOSED = 3'd4
   } parse_type;

   typedef enum logic [1:0] {
      KIND_CLIENT = 2'd0,
      KIND_HOST   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Source of the results of one request.
   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_REG  = 2'd1,
      MODE_ROM  = 2'd2,
      MODE_LINE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECODE = 2'd1,
      ST_EMIT   = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic job_none;
      logic out_free;
      logic seq_at_end;
   } dp_status_type;

   // Message table: greeting, SGA acknowledgement (its tail is the prompt), echo acknowledgement.
   function automatic logic [7:0] rom_byte(input logic [SEQ_W-1:0] idx);
      logic [7:0] val;
      case (idx)
         6'd0:  val = B_IAC;
         6'd1:  val = B_WILL;
         6'd2:  val = OPT_ECHO;
         6'd3:  val = B_IAC;
         6'd4:  val = B_WILL;
         6'd5:  val = OPT_SGA;
         6'd6:  val = 8'h73; // s
         6'd7:  val = 8'h65; // e
         6'd8:  val = 8'h72; // r
         6'd9:  val = 8'h76; // v
         6'd10: val = 8'h65; // e
         6'd11: val = 8'h72; // r
         6'd12: val = 8'h20;
         6'd13: val = 8'h53; // S
         6'd14: val = 8'h47; // G
         6'd15: val = 8'h41; // A
         6'd16: val = 8'h20;
         6'd17: val = 8'h4F; // O
         6'd18: val = 8'h4B; // K
         6'd19: val = 8'h21; // !
         6'd20: val = CH_CR;
         6'd21: val = CH_LF;
         6'd22: val = 8'h23; // #
         6'd23: val = 8'h73; // s
         6'd24: val = 8'h65; // e
         6'd25: val = 8'h72; // r
         6'd26: val = 8'h76; // v
         6'd27: val = 8'h65; // e
         6'd28: val = 8'h72; // r
         6'd29: val = 8'h20;
         6'd30: val = 8'h65; // e
         6'd31: val = 8'h63; // c
         6'd32: val = 8'h68; // h
         6'd33: val = 8'h6F; // o
         6'd34: val = 8'h20;
         6'd35: val = 8'h6F; // o
         6'd36: val = 8'h6B; // k
         6'd37: val = 8'h21; // !
         6'd38: val = CH_CR;
         6'd39: val = CH_LF;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

FILE: design/tnle_ram.sv
module tnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tnle_ctrl.sv
module tnle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tnle_pkg::dp_status_type status,
   output tnle_pkg::ctrl_cmd_type  cmd
);
   import tnle_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state: take a request, decode it, then stream its results if it has any.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.job_none ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.seq_at_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.decode  = 1'b0;
      cmd.emit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/tnle_dp.sv
module tnle_dp #(
   parameter int LINE_DEPTH = 62
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tnle_pkg::ctrl_cmd_type  cmd,
   output tnle_pkg::dp_status_type status,
   input  logic                    req_func,
   input  logic [7:0]              req_rx_byte,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_data_byte,
   output logic                    rsp_status_code,
   output logic                    rsp_last
);
   import tnle_pkg::*;

   localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);

   // Captured request.
   logic       item_func_ff;
   logic [7:0] item_byte_ff;

   // Session and line state.
   logic             enable_ff, enable_in;
   parse_type        parse_ff, parse_in;
   logic [7:0]       verb_ff, verb_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Result sequence.
   mode_type         mode_ff, mode_in;
   logic [SEQ_W-1:0] seq_idx_ff, seq_idx_in;
   logic [SEQ_W-1:0] seq_end_ff, seq_end_in;
   logic [7:0]       reply0_ff, reply0_in;
   logic [7:0]       reply1_ff, reply1_in;
   logic [7:0]       reply2_ff, reply2_in;
   kind_type         reply_kind_ff, reply_kind_in;
   logic             reply_status_ff, reply_status_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_status_ff;
   logic       rsp_last_ff;

   // Decoder results.
   parse_type        dec_parse;
   logic [7:0]       dec_verb;
   logic [CNT_W-1:0] dec_count;
   logic             dec_store;
   logic             dec_text;
   mode_type         dec_mode;
   logic [SEQ_W-1:0] dec_first;
   logic [SEQ_W-1:0] dec_last;
   logic [7:0]       dec_r0;
   logic [7:0]       dec_r1;
   logic [7:0]       dec_r2;
   kind_type         dec_kind;
   logic             dec_status;

   logic [7:0]       b;
   logic             at_end;
   logic             line_wr_en;
   logic [7:0]       line_rd_data;
   kind_type         emit_kind;
   logic [7:0]       emit_data;
   logic             emit_status;

   assign b = item_byte_ff;

   // Decode the captured request against the parser and line state.
   always_comb begin
      dec_parse  = parse_ff;
      dec_verb   = verb_ff;
      dec_count  = count_ff;
      dec_store  = 1'b0;
      dec_text   = 1'b0;
      dec_mode   = MODE_NONE;
      dec_first  = '0;
      dec_last   = '0;
      dec_r0     = b;
      dec_r1     = B_IAC;
      dec_r2     = b;
      dec_kind   = KIND_CLIENT;
      dec_status = STAT_REFUSED;
      if (item_func_ff) begin
         dec_parse = PS_TEXT;
         dec_verb  = 8'h00;
         dec_count = '0;
         dec_mode  = MODE_ROM;
         dec_first = ROM_GREET_FIRST;
         dec_last  = ROM_GREET_LAST;
      end else if (enable_ff) begin
         case (parse_ff)
            PS_IAC: begin
               if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
                  dec_verb  = b;
                  dec_parse = PS_VERB;
               end else begin
                  dec_parse = PS_TEXT;
                  if (b == B_IAC) begin
                     dec_mode = MODE_REG;
                     dec_r0   = B_IAC;
                  end
               end
            end
            PS_VERB: begin
               dec_parse = PS_TEXT;
               dec_mode  = MODE_REG;
               dec_last  = 6'd2;
               dec_r0    = B_IAC;
               dec_r1    = B_WONT;
               if (verb_ff == B_DO) begin
                  if (b == OPT_SGA) begin
                     dec_mode  = MODE_ROM;
                     dec_first = ROM_SGA_FIRST;
                     dec_last  = ROM_SGA_LAST;
                  end else if (b == OPT_ECHO) begin
                     dec_mode  = MODE_ROM;
                     dec_first = ROM_ECHO_FIRST;
                     dec_last  = ROM_ECHO_LAST;
                  end
               end else if (verb_ff == B_DONT) begin
                  // Client refuses echo or SGA: report and close the session.
                  if (b == OPT_SGA || b == OPT_ECHO) begin
                     dec_parse = PS_CLOSED;
                     dec_last  = '0;
                     dec_r0    = 8'h00;
                     dec_kind  = KIND_STATUS;
                  end
               end else begin
                  dec_r1 = B_DONT;
               end
            end
            PS_CR: begin
               dec_parse = PS_TEXT;
               dec_text  = (b != CH_LF) && (b != CH_NUL);
            end
            PS_TEXT: begin
               dec_text = 1'b1;
            end
            default: begin
               dec_parse = parse_ff;
            end
         endcase

         // Plain text handling.
         if (dec_text) begin
            if (b == B_IAC) begin
               dec_parse = PS_IAC;
            end else if (b == CH_CR) begin
               dec_parse = PS_CR;
               dec_count = '0;
               if (count_ff == '0) begin
                  dec_mode  = MODE_ROM;
                  dec_first = ROM_PROMPT_FIRST;
                  dec_last  = ROM_SGA_LAST;
               end else begin
                  dec_mode = MODE_LINE;
                  dec_last = SEQ_W'(count_ff - CNT_W'(1));
               end
            end else if (b == CH_LF) begin
               dec_mode = MODE_NONE;
            end else if (b == CH_BS) begin
               dec_mode = MODE_REG;
               if (count_ff != '0) begin
                  dec_count = count_ff - CNT_W'(1);
               end
            end else if (count_ff >= CNT_W'(LINE_DEPTH)) begin
               dec_mode   = MODE_REG;
               dec_r0     = 8'h00;
               dec_kind   = KIND_STATUS;
               dec_status = STAT_OVERFLOW;
            end else begin
               dec_mode  = MODE_REG;
               dec_store = 1'b1;
               dec_count = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Result sequencing.
   assign at_end            = (seq_idx_ff == seq_end_ff);
   assign status.job_none   = (dec_mode == MODE_NONE);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.seq_at_end = at_end;
   assign line_wr_en        = cmd.decode && dec_store;

   always_comb begin
      enable_in       = csr_wr_en ? csr_wr_data : enable_ff;
      parse_in        = cmd.decode ? dec_parse : parse_ff;
      verb_in         = cmd.decode ? dec_verb : verb_ff;
      count_in        = cmd.decode ? dec_count : count_ff;
      mode_in         = cmd.decode ? dec_mode : mode_ff;
      seq_end_in      = cmd.decode ? dec_last : seq_end_ff;
      reply0_in       = cmd.decode ? dec_r0 : reply0_ff;
      reply1_in       = cmd.decode ? dec_r1 : reply1_ff;
      reply2_in       = cmd.decode ? dec_r2 : reply2_ff;
      reply_kind_in   = cmd.decode ? dec_kind : reply_kind_ff;
      reply_status_in = cmd.decode ? dec_status : reply_status_ff;
      if (cmd.decode) begin
         seq_idx_in = dec_first;
      end else if (cmd.emit && !at_end) begin
         seq_idx_in = seq_idx_ff + SEQ_W'(1);
      end else begin
         seq_idx_in = seq_idx_ff;
      end
   end

   // The line store is read one entry ahead, at the index of the next cycle.
   tnle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (item_byte_ff),
      .rd_addr (seq_idx_in[ADDR_W-1:0]),
      .rd_data (line_rd_data)
   );

   // Select the result for the current index.
   always_comb begin
      emit_kind   = KIND_CLIENT;
      emit_data   = 8'h00;
      emit_status = STAT_REFUSED;
      case (mode_ff)
         MODE_REG: begin
            emit_kind   = reply_kind_ff;
            emit_status = reply_status_ff;
            case (seq_idx_ff[1:0])
               2'd0:    emit_data = reply0_ff;
               2'd1:    emit_data = reply1_ff;
               default: emit_data = reply2_ff;
            endcase
         end
         MODE_ROM: begin
            emit_data = rom_byte(seq_idx_ff);
         end
         MODE_LINE: begin
            emit_kind = KIND_HOST;
            emit_data = line_rd_data;
         end
         default: begin
            emit_data = 8'h00;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         parse_ff     <= PS_TEXT;
         verb_ff      <= 8'h00;
         count_ff     <= '0;
         mode_ff      <= MODE_NONE;
         seq_idx_ff   <= '0;
         seq_end_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         parse_ff     <= parse_in;
         verb_ff      <= verb_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         seq_idx_ff   <= seq_idx_in;
         seq_end_ff   <= seq_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_func_ff <= req_func;
         item_byte_ff <= req_rx_byte;
      end
      reply0_ff       <= reply0_in;
      reply1_ff       <= reply1_in;
      reply2_ff       <= reply2_in;
      reply_kind_ff   <= reply_kind_in;
      reply_status_ff <= reply_status_in;
      if (cmd.emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_data_ff   <= emit_data;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= at_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_status_code = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: design/telnet_option_negotiator_line_editor.sv
// The first result of a request is loaded into the output register after its capture and its decode.
// The results of a request then follow one another while the output is free (up to 17 for a message,
// up to LINE_DEPTH for a line dump); the result counter steps them into the output register.
// The input is stalled from acceptance until the last result is loaded into the output register.
// Reset (synchronous, active high) restores text mode, an empty line and enable set to one.
module telnet_option_negotiator_line_editor #(
   parameter int LINE_DEPTH = 62
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_status_code,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import tnle_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tnle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tnle_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_rx_byte     (req_rx_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_status_code (rsp_status_code),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // An accepted request is decoded in the next cycle.
   a_accept_decode : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.decode)
      else $error("accepted request was not decoded");

   // A status event is always the only result of its request.
   a_status_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STATUS) |-> rsp_last)
      else $error("status event not marked last");

   // A new result appears only after the controller issued an emit.
   a_valid_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result appeared without emit");
`endif

endmodule

FILE: tb/telnet_option_negotiator_line_editor_test.sv
`timescale 1ns / 1ps

module telnet_option_negotiator_line_editor_test;
   import tnle_pkg::*;

   localparam int LINE_CAP      = 62;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 5000000;
   localparam int RANDOM_ITEMS  = 375;
   localparam logic [7:0] CH_PROMPT = 8'h23;

   // One entry of the stimulus feed: either a request or a write of the enable register.
   typedef struct {
      bit         enable_write;
      bit         enable_value;
      logic       func;
      logic [7:0] rx_byte;
      int         gap;
   } feed_entry_type;

   // One reply of the block as the checker expects it.
   typedef struct {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       status_code;
      logic       last;
   } reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_func = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic       rsp_status_code;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   feed_entry_type feed_q[$];
   reply_type      reply_q[$];

   // Own copy of the session state.
   bit          rx_enable = 1'b1;
   parse_type   sess_state = PS_TEXT;
   logic [7:0]  sess_verb = 8'h00;
   logic [7:0]  line_buf[LINE_CAP];
   int          line_len = 0;

   // Handshake flags sampled at the rising edge, used by the falling-edge drivers.
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;

   bit          drv_busy = 1'b0;
   bit          gap_armed = 1'b0;
   int          gap_left = 0;
   int          drv_settle = SETTLE_CYCLES;
   bit          rsp_calm = 1'b0;
   int          rsp_hold = 0;

   bit          feed_calm = 1'b0;
   bit          count_random = 1'b0;
   int          random_items = 0;
   int          fault_count = 0;
   int          cycle_count = 0;

   telnet_option_negotiator_line_editor #(
      .LINE_DEPTH(LINE_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_status_code(rsp_status_code),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Appends one reply; the last flag is fixed up once the request is fully handled.
   function automatic void add_reply(kind_type kind, logic [7:0] data_byte, logic status_code);
      reply_type r;
      r.kind        = kind;
      r.data_byte   = data_byte;
      r.status_code = status_code;
      r.last        = 1'b0;
      reply_q.push_back(r);
   endfunction

   function automatic void send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_reply(KIND_CLIENT, s[i], 1'b0);
      end
   endfunction

   function automatic void queue_iac_reply(logic [7:0] verb, logic [7:0] option);
      add_reply(KIND_CLIENT, B_IAC, 1'b0);
      add_reply(KIND_CLIENT, verb, 1'b0);
      add_reply(KIND_CLIENT, option, 1'b0);
   endfunction

   // Line editing of one byte in text mode.
   function automatic void edit_line(logic [7:0] b);
      if (b == B_IAC) begin
         sess_state = PS_IAC;
      end else if (b == CH_CR) begin
         if (line_len == 0) begin
            add_reply(KIND_CLIENT, CH_CR, 1'b0);
            add_reply(KIND_CLIENT, CH_LF, 1'b0);
            add_reply(KIND_CLIENT, CH_PROMPT, 1'b0);
         end else begin
            for (int i = 0; i < line_len; i++) begin
               add_reply(KIND_HOST, line_buf[i], 1'b0);
            end
         end
         line_len   = 0;
         sess_state = PS_CR;
      end else if (b == CH_LF) begin
         // A bare line feed is dropped.
      end else if (b == CH_BS) begin
         if (line_len > 0) begin
            line_len--;
         end
         add_reply(KIND_CLIENT, b, 1'b0);
      end else if (line_len >= LINE_CAP) begin
         add_reply(KIND_STATUS, 8'h00, STAT_OVERFLOW);
      end else begin
         add_reply(KIND_CLIENT, b, 1'b0);
         line_buf[line_len] = b;
         line_len++;
      end
   endfunction

   // Works out the replies that one accepted request causes.
   function automatic void negotiate_request(logic func, logic [7:0] b);
      int        first;
      reply_type tail;
      first = reply_q.size();
      if (func) begin
         sess_state = PS_TEXT;
         sess_verb  = 8'h00;
         line_len   = 0;
         queue_iac_reply(B_WILL, OPT_ECHO);
         queue_iac_reply(B_WILL, OPT_SGA);
      end else if (rx_enable) begin
         case (sess_state)
            PS_IAC: begin
               if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
                  sess_verb  = b;
                  sess_state = PS_VERB;
               end else begin
                  if (b == B_IAC) begin
                     add_reply(KIND_CLIENT, B_IAC, 1'b0);
                  end
                  sess_state = PS_TEXT;
               end
            end
            PS_VERB: begin
               sess_state = PS_TEXT;
               if (sess_verb == B_DO) begin
                  if (b == OPT_SGA) begin
                     send_text("server SGA OK!");
                     add_reply(KIND_CLIENT, CH_CR, 1'b0);
                     add_reply(KIND_CLIENT, CH_LF, 1'b0);
                     add_reply(KIND_CLIENT, CH_PROMPT, 1'b0);
                  end else if (b == OPT_ECHO) begin
                     send_text("server echo ok!");
                     add_reply(KIND_CLIENT, CH_CR, 1'b0);
                     add_reply(KIND_CLIENT, CH_LF, 1'b0);
                  end else begin
                     queue_iac_reply(B_WONT, b);
                  end
               end else if (sess_verb == B_DONT) begin
                  if (b == OPT_SGA || b == OPT_ECHO) begin
                     add_reply(KIND_STATUS, 8'h00, STAT_REFUSED);
                     sess_state = PS_CLOSED;
                  end else begin
                     queue_iac_reply(B_WONT, b);
                  end
               end else begin
                  queue_iac_reply(B_DONT, b);
               end
            end
            PS_CR: begin
               sess_state = PS_TEXT;
               if (b != CH_LF && b != CH_NUL) begin
                  edit_line(b);
               end
            end
            PS_TEXT: begin
               edit_line(b);
            end
            default: begin
               // The session is closed until the next session start.
            end
         endcase
      end
      if (reply_q.size() > first) begin
         tail      = reply_q.pop_back();
         tail.last = 1'b1;
         reply_q.push_back(tail);
      end
   endfunction

   // Rising edge: register writes, result checks, prediction of accepted requests.
   always @(posedge clock) begin : check_results
      reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rx_enable = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected result: kind %0d data %02h status %0d last %0d",
                           rsp_kind, rsp_data_byte, rsp_status_code, rsp_last);
               end
            end else begin
               want = reply_q.pop_front();
               if (rsp_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_status_code !== want.status_code || rsp_last !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $write("mismatch: expected kind %0d data %02h status %0d last %0d, ",
                            want.kind, want.data_byte, want.status_code, want.last);
                     $display("got kind %0d data %02h status %0d last %0d",
                              rsp_kind, rsp_data_byte, rsp_status_code, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            negotiate_request(req_func, req_rx_byte);
         end
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
      end
   end

   // Request driver: one request at a time from the feed, register writes only when idle.
   always @(negedge clock) begin : drive_requests
      logic next_valid;
      logic next_we;
      logic next_wd;
      if (!reset) begin
         next_valid = req_valid;
         next_we    = 1'b0;
         next_wd    = csr_wr_data;
         if (drv_busy && req_taken) begin
            drv_busy   = 1'b0;
            next_valid = 1'b0;
         end
         if (!drv_busy && feed_q.size() != 0) begin
            if (feed_q[0].enable_write) begin
               if (reply_q.size() != 0 || rsp_valid) begin
                  drv_settle = SETTLE_CYCLES;
               end else if (drv_settle != 0) begin
                  drv_settle--;
               end else begin
                  next_we    = 1'b1;
                  next_wd    = feed_q[0].enable_value;
                  feed_q.delete(0);
                  drv_settle = SETTLE_CYCLES;
               end
            end else begin
               if (!gap_armed) begin
                  gap_left  = feed_q[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  req_func    <= feed_q[0].func;
                  req_rx_byte <= feed_q[0].rx_byte;
                  feed_q.delete(0);
                  drv_busy   = 1'b1;
                  gap_armed  = 1'b0;
                  next_valid = 1'b1;
               end
            end
         end
         req_valid   <= next_valid;
         csr_wr_en   <= next_we;
         csr_wr_data <= next_wd;
      end
   end

   // Result side: each result is held off a random number of cycles, with calm stretches.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) begin
               rsp_calm = !rsp_calm;
            end
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 16);
         end
         if (rsp_valid && rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_item(logic func, logic [7:0] rx_byte);
      feed_entry_type e;
      e.enable_write = 1'b0;
      e.enable_value = 1'b0;
      e.func         = func;
      e.rx_byte      = rx_byte;
      e.gap          = (feed_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
      feed_q.push_back(e);
      if (count_random) begin
         random_items++;
      end
   endtask

   task automatic push_enable(bit value);
      feed_entry_type e;
      e.enable_write = 1'b1;
      e.enable_value = value;
      e.func         = 1'b0;
      e.rx_byte      = 8'h00;
      e.gap          = 0;
      feed_q.push_back(e);
   endtask

   // Mostly printable characters, now and then any byte at all.
   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) begin
         b = 8'($urandom_range(0, 255));
      end else begin
         b = 8'($urandom_range(32, 126));
      end
      return b;
   endfunction

   task automatic push_long_line(int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(32, 126));
         push_item(1'b0, b);
      end
      push_item(1'b0, CH_CR);
   endtask

   // One well-formed exchange with random content, or a little noise.
   task automatic push_random_sequence();
      int         sel;
      int         n;
      logic [7:0] verb;
      logic [7:0] option;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         // A typed line with the odd backspace, ended by CR and maybe LF or NUL.
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++) begin
            push_item(1'b0, ($urandom_range(0, 9) == 0) ? CH_BS : pick_text_byte());
         end
         push_item(1'b0, CH_CR);
         case ($urandom_range(0, 2))
            0: push_item(1'b0, CH_LF);
            1: push_item(1'b0, CH_NUL);
            default: ;
         endcase
      end else if (sel < 60) begin
         // Option negotiation; a refused echo or SGA closes the session.
         case ($urandom_range(0, 3))
            0: verb = B_DO;
            1: verb = B_DONT;
            2: verb = B_WILL;
            default: verb = B_WONT;
         endcase
         if ($urandom_range(0, 2) == 0) begin
            option = 8'($urandom_range(0, 255));
         end else begin
            option = $urandom_range(0, 1) ? OPT_ECHO : OPT_SGA;
         end
         push_item(1'b0, B_IAC);
         push_item(1'b0, verb);
         push_item(1'b0, option);
         if (verb == B_DONT && (option == OPT_ECHO || option == OPT_SGA)) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               push_item(1'b0, 8'($urandom_range(0, 255)));
            end
            push_item(1'b1, 8'($urandom_range(0, 255)));
         end
      end else if (sel < 70) begin
         // Escaped IAC or some other command after IAC.
         push_item(1'b0, B_IAC);
         push_item(1'b0, $urandom_range(0, 1) ? B_IAC : 8'($urandom_range(0, 255)));
      end else if (sel < 80) begin
         // A few characters and then more backspaces than characters, now and then.
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            push_item(1'b0, 8'($urandom_range(32, 126)));
         end
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            push_item(1'b0, CH_BS);
         end
      end else if (sel < 85) begin
         push_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (sel < 87) begin
         push_long_line($urandom_range(58, 70));
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            push_item(($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Stimulus, reset and the end of the run.
   initial begin
      // Opening checks: greeting, each verb, escapes, line editing and a refusal.
      push_enable(1'b1);
      push_item(1'b1, 8'hFF);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DO);
      push_item(1'b0, OPT_SGA);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DO);
      push_item(1'b0, OPT_ECHO);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DO);
      push_item(1'b0, 8'h22);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DONT);
      push_item(1'b0, 8'h00);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_WILL);
      push_item(1'b0, 8'h1F);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_WONT);
      push_item(1'b0, 8'hFF);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_IAC);
      push_item(1'b0, 8'hF1);
      push_item(1'b0, CH_BS);
      push_item(1'b0, 8'h80);
      push_item(1'b0, CH_CR);
      push_item(1'b0, CH_LF);
      push_item(1'b0, CH_CR);
      push_item(1'b0, CH_NUL);
      push_item(1'b0, CH_LF);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DONT);
      push_item(1'b0, OPT_ECHO);
      push_item(1'b0, 8'h41);
      push_item(1'b1, 8'h00);

      // With reception disabled only the session start gives replies.
      push_enable(1'b0);
      push_item(1'b0, B_IAC);
      push_item(1'b0, B_DO);
      push_item(1'b0, OPT_SGA);
      push_item(1'b1, 8'h5A);
      push_item(1'b0, 8'h61);
      push_item(1'b0, CH_CR);
      push_enable(1'b1);

      // Random part, starting with a line that overflows the store.
      count_random = 1'b1;
      push_long_line(66);
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 29) == 0) begin
            feed_calm = !feed_calm;
         end
         if ($urandom_range(0, 59) == 0) begin
            count_random = 1'b0;
            push_enable(1'b0);
            for (int i = 0; i < 4; i++) begin
               push_item(($urandom_range(0, 5) == 0), 8'($urandom_range(0, 255)));
            end
            push_enable(1'b1);
            count_random = 1'b1;
         end
         push_random_sequence();
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (feed_q.size() != 0 || drv_busy || reply_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && reply_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
